// ===== hw/rtl/ooo_sched_pkg.sv =====
`timescale 1ns / 1ps
package ooo_sched_pkg;

	localparam int REG_COUNT      = 128;
	localparam int MAX_UNITS      = 4;
	localparam int MAX_BUSES      = 4;
	localparam int SLOT_COUNT     = 32;
	localparam int DISPATCH_DEPTH = 64;

	localparam logic [15:0] AGE_MAX = 16'hFFFF;

	localparam logic CMD_FETCH = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [1:0] CLS_0 = 2'd0;
	localparam logic [1:0] CLS_1 = 2'd1;
	localparam logic [1:0] CLS_2 = 2'd2;

	localparam logic [1:0] REG_CLASS0 = 2'd0;
	localparam logic [1:0] REG_CLASS1 = 2'd1;
	localparam logic [1:0] REG_CLASS2 = 2'd2;
	localparam logic [1:0] REG_BUSES  = 2'd3;

	typedef struct packed {
		logic [1:0] cls;
		logic [7:0] dest;
		logic [7:0] s1;
		logic [7:0] s2;
	} dq_item_t;

	typedef struct packed {
		logic        valid;
		logic        issued;
		logic        done;
		logic        retire;
		logic        rdy1;
		logic        rdy2;
		logic [1:0]  cls;
		logic        dvalid;
		logic [7:0]  dest;
		logic [31:0] tag;
		logic [31:0] t1;
		logic [31:0] t2;
		logic [15:0] age;
	} slot_t;

	function automatic logic [1:0] decode_class(input logic [2:0] v);
		logic [1:0] c;
		unique case (v)
			3'd0:    c = CLS_0;
			3'd2:    c = CLS_2;
			default: c = CLS_1;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ooo_sched_ram.sv =====
`timescale 1ns / 1ps
module ooo_sched_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hw/rtl/ooo_sched_front.sv =====
`timescale 1ns / 1ps
module ooo_sched_front #(
	parameter int DEPTH = ooo_sched_pkg::DISPATCH_DEPTH,
	localparam int DW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fetch,
	input  ooo_sched_pkg::dq_item_t   item,
	input  logic                      pop,
	output ooo_sched_pkg::dq_item_t   entry,
	output logic [DW:0]               count,
	output logic                      done,
	output logic                      accepted
);

	logic [DW-1:0] head_q;
	logic [DW:0]   count_q;
	logic          done_q;
	logic          acc_q;
	logic [DW:0]   tail_sum;
	logic [DW-1:0] tail;
	logic          full;
	logic          we;
	logic [DW-1:0] addr;

	assign full     = (count_q == (DW+1)'(DEPTH));
	assign tail_sum = {1'b0, head_q} + count_q;
	assign tail     = (tail_sum >= (DW+1)'(DEPTH)) ? DW'(tail_sum - (DW+1)'(DEPTH))
	                                              : tail_sum[DW-1:0];
	assign we       = fetch && !full;
	assign addr     = we ? tail : head_q;

	ooo_sched_ram #(.WIDTH($bits(ooo_sched_pkg::dq_item_t)), .DEPTH(DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(item),
		.rdata(entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
		end else begin
			done_q <= fetch;
			if (fetch) begin
				acc_q <= !full;
			end
			if (we) begin
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= (head_q == DW'(DEPTH-1)) ? '0 : head_q + 1'b1;
			end
		end
	end

	assign count    = count_q;
	assign done     = done_q;
	assign accepted = acc_q;

endmodule

// ===== hw/rtl/ooo_sched_back.sv =====
`timescale 1ns / 1ps
module ooo_sched_back #(
	parameter int REG_COUNT  = ooo_sched_pkg::REG_COUNT,
	parameter int MAX_UNITS  = ooo_sched_pkg::MAX_UNITS,
	parameter int MAX_BUSES  = ooo_sched_pkg::MAX_BUSES,
	parameter int SLOT_COUNT = ooo_sched_pkg::SLOT_COUNT,
	parameter int QW         = 7,
	localparam int UW  = $clog2(MAX_UNITS+1),
	localparam int NBW = $clog2(MAX_BUSES+1),
	localparam int BW  = (MAX_BUSES > 1) ? $clog2(MAX_BUSES) : 1,
	localparam int SW  = $clog2(SLOT_COUNT),
	localparam int NSW = $clog2(SLOT_COUNT+1),
	localparam int RW  = $clog2(REG_COUNT)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tick,
	input  logic [UW-1:0]           lim0,
	input  logic [UW-1:0]           lim1,
	input  logic [UW-1:0]           lim2,
	input  logic [NBW-1:0]          nbus,
	input  logic [NSW-1:0]          nslot,
	input  logic [QW-1:0]           q_count,
	input  ooo_sched_pkg::dq_item_t q_entry,
	output logic                    pop,
	output logic                    done,
	output logic [31:0]             cycle,
	output logic [5:0]              ndisp,
	output logic [5:0]              nfire,
	output logic [2:0]              ndone,
	output logic [5:0]              nret,
	output logic                    any_valid
);

	typedef enum logic [14:0] {
		B_IDLE  = 15'b000000000000001,
		B_WALK  = 15'b000000000000010,
		B_REL   = 15'b000000000000100,
		B_GBUS  = 15'b000000000001000,
		B_GWALK = 15'b000000000010000,
		B_GRD   = 15'b000000000100000,
		B_GAPP  = 15'b000000001000000,
		B_FWALK = 15'b000000010000000,
		B_FAPP  = 15'b000000100000000,
		B_DFIND = 15'b000001000000000,
		B_DS1   = 15'b000010000000000,
		B_DS2   = 15'b000100000000000,
		B_DWR   = 15'b001000000000000,
		B_RET   = 15'b010000000000000,
		B_DONE  = 15'b100000000000000
	} bstate_t;

	bstate_t state_q;

	ooo_sched_pkg::slot_t slot_q [SLOT_COUNT];
	ooo_sched_pkg::slot_t cur;
	ooo_sched_pkg::slot_t wk;
	ooo_sched_pkg::dq_item_t ent_q;

	logic [SW-1:0]    i_q;
	logic [NBW-1:0]   j_q;
	logic [SW-1:0]    best_q;
	logic             found_q;
	logic [31:0]      best_tag_q;
	logic [15:0]      best_age_q;
	logic [1:0]       best_cls_q;
	logic             best_dv_q;
	logic [7:0]       best_dest_q;
	logic [MAX_BUSES-1:0] rel_q;
	logic [MAX_BUSES-1:0] rel;
	logic [SLOT_COUNT-1:0] tried_q;
	logic [SLOT_COUNT-1:0] valid_v;
	logic [SLOT_COUNT-1:0] retire_v;
	logic [UW-1:0]    units_q [3];
	logic [UW-1:0]    lim [3];
	logic             bus_busy_q [MAX_BUSES];
	logic [31:0]      bus_tag_q [MAX_BUSES];
	logic [REG_COUNT-1:0] notready_q;
	logic [31:0]      next_tag_q;
	logic [31:0]      cycle_q;
	logic [5:0]       ndisp_q;
	logic [5:0]       nfire_q;
	logic [2:0]       ndone_q;
	logic [5:0]       nret_q;
	logic             r1_q;
	logic [31:0]      t1_q;

	logic             last_i;
	logic             g_better;
	logic             f_cand;
	logic             f_better;
	logic             better;
	logic             ram_we;
	logic [RW-1:0]    ram_addr;
	logic [31:0]      ram_rdata;
	logic [31:0]      tag_inc;
	logic             s_ok;
	logic [RW-1:0]    s_idx;
	logic [7:0]       s_raw;
	logic             d_ok;
	logic [RW-1:0]    d_idx;
	logic             r2;
	logic [31:0]      t2;
	logic             hit;

	assign lim[0] = lim0;
	assign lim[1] = lim1;
	assign lim[2] = lim2;

	assign cur    = slot_q[i_q];
	assign last_i = (i_q == SW'(SLOT_COUNT-1));

	always_comb begin
		wk  = cur;
		rel = '0;
		hit = 1'b0;
		for (int j = 0; j < MAX_BUSES; j++) begin
			if (cur.valid && bus_busy_q[j]) begin
				if (!cur.rdy1 && cur.t1 == bus_tag_q[j]) begin
					wk.rdy1 = 1'b1;
					wk.t1   = '0;
				end
				if (!cur.rdy2 && cur.t2 == bus_tag_q[j]) begin
					wk.rdy2 = 1'b1;
					wk.t2   = '0;
				end
			end
			if (cur.done && !hit && bus_busy_q[j] && bus_tag_q[j] == cur.tag) begin
				rel[j] = 1'b1;
				hit    = 1'b1;
			end
		end
		if (cur.done) begin
			wk.done   = 1'b0;
			wk.retire = 1'b1;
		end
		if (cur.issued && cur.age != ooo_sched_pkg::AGE_MAX) begin
			wk.age = cur.age + 1'b1;
		end
	end

	assign g_better = cur.issued && (!found_q || cur.age > best_age_q ||
	                  (cur.age == best_age_q && cur.tag < best_tag_q));
	assign f_cand   = cur.valid && cur.rdy1 && cur.rdy2 && !cur.issued && !cur.done &&
	                  !cur.retire && !tried_q[i_q];
	assign f_better = f_cand && (!found_q || cur.tag < best_tag_q);
	assign better   = (state_q == B_GWALK) ? g_better : f_better;

	assign tag_inc = (next_tag_q == 32'hFFFF_FFFF) ? 32'd1 : next_tag_q + 1'b1;

	always_comb begin
		s_raw = (state_q == B_DS1) ? q_entry.s1 : ent_q.s2;
		s_ok  = !s_raw[7] && ({1'b0, s_raw} < 9'(REG_COUNT));
		s_idx = s_raw[RW-1:0];
		d_ok  = !ent_q.dest[7] && ({1'b0, ent_q.dest} < 9'(REG_COUNT));
		d_idx = ent_q.dest[RW-1:0];
		r2    = !s_ok || !notready_q[s_idx];
		t2    = r2 ? 32'd0 : ram_rdata;
	end

	always_comb begin
		ram_we   = 1'b0;
		ram_addr = '0;
		unique case (state_q)
			B_GRD: ram_addr = best_dest_q[RW-1:0];
			B_DS1, B_DS2: ram_addr = s_idx;
			B_DWR: begin
				ram_addr = d_idx;
				ram_we   = d_ok;
			end
			default: ram_addr = '0;
		endcase
	end

	ooo_sched_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_regtag (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(next_tag_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int k = 0; k < SLOT_COUNT; k++) begin
			valid_v[k]  = slot_q[k].valid;
			retire_v[k] = slot_q[k].retire;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			for (int k = 0; k < SLOT_COUNT; k++) begin
				slot_q[k] <= '0;
			end
			for (int k = 0; k < MAX_BUSES; k++) begin
				bus_busy_q[k] <= 1'b0;
				bus_tag_q[k]  <= '0;
			end
			for (int k = 0; k < 3; k++) begin
				units_q[k] <= '0;
			end
			notready_q <= '0;
			next_tag_q <= '0;
			cycle_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			rel_q      <= '0;
			tried_q    <= '0;
			ndisp_q    <= '0;
			nfire_q    <= '0;
			ndone_q    <= '0;
			nret_q     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (tick) begin
						i_q     <= '0;
						rel_q   <= '0;
						ndisp_q <= '0;
						nfire_q <= '0;
						ndone_q <= '0;
						state_q <= B_WALK;
					end
				end
				B_WALK: begin
					slot_q[i_q] <= wk;
					rel_q       <= rel_q | rel;
					if (last_i) begin
						state_q <= B_REL;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				B_REL: begin
					for (int k = 0; k < MAX_BUSES; k++) begin
						if (rel_q[k]) begin
							bus_busy_q[k] <= 1'b0;
							bus_tag_q[k]  <= '0;
						end
					end
					j_q     <= '0;
					state_q <= B_GBUS;
				end
				B_GBUS: begin
					i_q     <= '0;
					found_q <= 1'b0;
					if (j_q >= nbus) begin
						tried_q <= '0;
						state_q <= B_FWALK;
					end else if (bus_busy_q[j_q[BW-1:0]]) begin
						j_q <= j_q + 1'b1;
					end else begin
						state_q <= B_GWALK;
					end
				end
				B_GWALK, B_FWALK: begin
					if (better) begin
						found_q     <= 1'b1;
						best_q      <= i_q;
						best_tag_q  <= cur.tag;
						best_age_q  <= cur.age;
						best_cls_q  <= cur.cls;
						best_dv_q   <= cur.dvalid;
						best_dest_q <= cur.dest;
					end
					if (last_i) begin
						if (state_q == B_GWALK) begin
							if (found_q || better) begin
								state_q <= B_GRD;
							end else begin
								j_q     <= j_q + 1'b1;
								state_q <= B_GBUS;
							end
						end else begin
							if (found_q || better) begin
								state_q <= B_FAPP;
							end else begin
								i_q     <= '0;
								state_q <= B_DFIND;
							end
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				B_GRD: state_q <= B_GAPP;
				B_GAPP: begin
					slot_q[best_q].issued <= 1'b0;
					slot_q[best_q].done   <= 1'b1;
					slot_q[best_q].age    <= '0;
					bus_busy_q[j_q[BW-1:0]] <= 1'b1;
					bus_tag_q[j_q[BW-1:0]]  <= best_tag_q;
					if (best_dv_q && notready_q[best_dest_q[RW-1:0]] &&
					    ram_rdata == best_tag_q) begin
						notready_q[best_dest_q[RW-1:0]] <= 1'b0;
					end
					if (units_q[best_cls_q] != '0) begin
						units_q[best_cls_q] <= units_q[best_cls_q] - 1'b1;
					end
					ndone_q <= ndone_q + 1'b1;
					j_q     <= j_q + 1'b1;
					state_q <= B_GBUS;
				end
				B_FAPP: begin
					tried_q[best_q] <= 1'b1;
					if (units_q[best_cls_q] < lim[best_cls_q]) begin
						units_q[best_cls_q]   <= units_q[best_cls_q] + 1'b1;
						slot_q[best_q].issued <= 1'b1;
						slot_q[best_q].age    <= '0;
						nfire_q               <= nfire_q + 1'b1;
					end
					i_q     <= '0;
					found_q <= 1'b0;
					state_q <= B_FWALK;
				end
				B_DFIND: begin
					if (q_count == '0 || NSW'(i_q) >= nslot) begin
						state_q <= B_RET;
					end else if (!cur.valid) begin
						state_q <= B_DS1;
					end else if (last_i) begin
						state_q <= B_RET;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				B_DS1: begin
					ent_q      <= q_entry;
					r1_q       <= r2;
					next_tag_q <= tag_inc;
					state_q    <= B_DS2;
				end
				B_DS2: begin
					t1_q    <= r1_q ? 32'd0 : ram_rdata;
					state_q <= B_DWR;
				end
				B_DWR: begin
					slot_q[i_q] <= '{valid: 1'b1, issued: 1'b0, done: 1'b0, retire: 1'b0,
					                rdy1: r1_q, rdy2: r2, cls: ent_q.cls, dvalid: d_ok,
					                dest: ent_q.dest, tag: next_tag_q, t1: t1_q, t2: t2,
					                age: 16'd0};
					if (d_ok) begin
						notready_q[d_idx] <= 1'b1;
					end
					ndisp_q <= ndisp_q + 1'b1;
					if (last_i) begin
						state_q <= B_RET;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= B_DFIND;
					end
				end
				B_RET: begin
					for (int k = 0; k < SLOT_COUNT; k++) begin
						if (slot_q[k].retire) begin
							slot_q[k] <= '0;
						end
					end
					nret_q  <= 6'($countones(retire_v));
					cycle_q <= cycle_q + 1'b1;
					state_q <= B_DONE;
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign pop       = (state_q == B_DFIND) && q_count != '0 && NSW'(i_q) < nslot &&
	                   !cur.valid;
	assign done      = (state_q == B_DONE);
	assign cycle     = cycle_q;
	assign ndisp     = ndisp_q;
	assign nfire     = nfire_q;
	assign ndone     = ndone_q;
	assign nret      = nret_q;
	assign any_valid = |valid_v;

endmodule

// ===== hw/rtl/out_of_order_issue_scheduler_top.sv =====
`timescale 1ns / 1ps
// Fetch: done is registered via fetch_q, the front end's done_q and done_q here.
// A new start is taken once busy falls. Tick: the back end walks every slot, then
// the slots per free bus and per fire attempt, then dispatches and retires.
// One item at a time; busy covers it. Receiver cannot stall: done is one cycle per item.
// Async active-low reset empties the queue and slots, marks all registers ready.
module out_of_order_issue_scheduler_top #(
	parameter int REG_COUNT      = ooo_sched_pkg::REG_COUNT,
	parameter int MAX_UNITS      = ooo_sched_pkg::MAX_UNITS,
	parameter int MAX_BUSES      = ooo_sched_pkg::MAX_BUSES,
	parameter int SLOT_COUNT     = ooo_sched_pkg::SLOT_COUNT,
	parameter int DISPATCH_DEPTH = ooo_sched_pkg::DISPATCH_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic signed [2:0] op_class,
	input  logic signed [7:0] dst_reg,
	input  logic signed [7:0] src1_reg,
	input  logic signed [7:0] src2_reg,
	output logic              done,
	output logic              accepted,
	output logic [31:0]       cycle_number,
	output logic [5:0]        dispatched,
	output logic [5:0]        fired,
	output logic [2:0]        completed,
	output logic [5:0]        retired,
	output logic [6:0]        queue_fill,
	output logic              idle
);

	localparam int UW  = $clog2(MAX_UNITS+1);
	localparam int NBW = $clog2(MAX_BUSES+1);
	localparam int NSW = $clog2(SLOT_COUNT+1);
	localparam int QW  = $clog2(DISPATCH_DEPTH) + 1;

	logic [2:0]    cfg_q [4];
	logic [UW-1:0] lim [3];
	logic [NBW-1:0] nbus;
	logic [NSW-1:0] nslot;
	int            nbus_i;
	int            lim_i [3];
	int            nslot_i;

	logic          busy_q;
	logic          fetch_q;
	logic          tick_q;
	ooo_sched_pkg::dq_item_t item_q;
	ooo_sched_pkg::dq_item_t q_entry;
	logic [QW-1:0] q_count;
	logic          pop;
	logic          f_done;
	logic          f_acc;
	logic          b_done;
	logic [31:0]   b_cycle;
	logic [5:0]    b_ndisp;
	logic [5:0]    b_nfire;
	logic [2:0]    b_ndone;
	logic [5:0]    b_nret;
	logic          b_any;
	logic          go;

	logic          done_q;
	logic          acc_q;
	logic [31:0]   cyc_q;
	logic [5:0]    disp_q;
	logic [5:0]    fire_q;
	logic [2:0]    comp_q;
	logic [5:0]    ret_q;
	logic [6:0]    fill_q;
	logic          idle_q;

	assign pready = 1'b1;
	assign prdata = {29'd0, cfg_q[paddr[3:2]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				cfg_q[k] <= 3'd1;
			end
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				ooo_sched_pkg::REG_CLASS0: cfg_q[0] <= pwdata[2:0];
				ooo_sched_pkg::REG_CLASS1: cfg_q[1] <= pwdata[2:0];
				ooo_sched_pkg::REG_CLASS2: cfg_q[2] <= pwdata[2:0];
				ooo_sched_pkg::REG_BUSES:  cfg_q[3] <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (cfg_q[k] == 3'd0) begin
				lim_i[k] = 1;
			end else if (int'(cfg_q[k]) > MAX_UNITS) begin
				lim_i[k] = MAX_UNITS;
			end else begin
				lim_i[k] = int'(cfg_q[k]);
			end
			lim[k] = UW'(lim_i[k]);
		end
		if (cfg_q[3] == 3'd0) begin
			nbus_i = 1;
		end else if (int'(cfg_q[3]) > MAX_BUSES) begin
			nbus_i = MAX_BUSES;
		end else begin
			nbus_i = int'(cfg_q[3]);
		end
		nbus    = NBW'(nbus_i);
		nslot_i = 2 * (lim_i[0] + lim_i[1] + lim_i[2]);
		if (nslot_i > SLOT_COUNT) begin
			nslot_i = SLOT_COUNT;
		end
		nslot = NSW'(nslot_i);
	end

	assign go = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fetch_q <= 1'b0;
			tick_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			fetch_q <= go && (command == ooo_sched_pkg::CMD_FETCH);
			tick_q  <= go && (command == ooo_sched_pkg::CMD_TICK);
			done_q  <= f_done || b_done;
			if (go) begin
				busy_q <= 1'b1;
			end else if (f_done || b_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			item_q <= '{cls: ooo_sched_pkg::decode_class(op_class), dest: dst_reg,
			            s1: src1_reg, s2: src2_reg};
		end
		if (f_done || b_done) begin
			acc_q  <= f_done ? f_acc : 1'b0;
			cyc_q  <= b_cycle;
			disp_q <= b_done ? b_ndisp : 6'd0;
			fire_q <= b_done ? b_nfire : 6'd0;
			comp_q <= b_done ? b_ndone : 3'd0;
			ret_q  <= b_done ? b_nret : 6'd0;
			fill_q <= q_count[6:0];
			idle_q <= (q_count == '0) && !b_any;
		end
	end

	ooo_sched_front #(.DEPTH(DISPATCH_DEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.fetch   (fetch_q),
		.item    (item_q),
		.pop     (pop),
		.entry   (q_entry),
		.count   (q_count),
		.done    (f_done),
		.accepted(f_acc)
	);

	ooo_sched_back #(
		.REG_COUNT (REG_COUNT),
		.MAX_UNITS (MAX_UNITS),
		.MAX_BUSES (MAX_BUSES),
		.SLOT_COUNT(SLOT_COUNT),
		.QW        (QW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_q),
		.lim0     (lim[0]),
		.lim1     (lim[1]),
		.lim2     (lim[2]),
		.nbus     (nbus),
		.nslot    (nslot),
		.q_count  (q_count),
		.q_entry  (q_entry),
		.pop      (pop),
		.done     (b_done),
		.cycle    (b_cycle),
		.ndisp    (b_ndisp),
		.nfire    (b_nfire),
		.ndone    (b_ndone),
		.nret     (b_nret),
		.any_valid(b_any)
	);

	assign busy         = busy_q;
	assign done         = done_q;
	assign accepted     = acc_q;
	assign cycle_number = cyc_q;
	assign dispatched   = disp_q;
	assign fired        = fire_q;
	assign completed    = comp_q;
	assign retired      = ret_q;
	assign queue_fill   = fill_q;
	assign idle         = idle_q;

endmodule
